@@ rtl/core/gbl_pkg.sv @@
`default_nettype none
package gbl_pkg;

    localparam int OFFSET_BITS      = 40;
    localparam int BUCKET_ID_BITS   = 16;
    localparam int WS_BITS          = 17;
    localparam int START_ALIGN_BITS = 6;
    localparam int END_ALIGN_LOG2   = 7;
    localparam int WIDE_ALIGN_LOG2  = 16;
    localparam int LCM_BITS         = WS_BITS + WIDE_ALIGN_LOG2;
    localparam int TZ_BITS          = $clog2(WS_BITS);
    localparam int DIV_CNT_BITS     = $clog2(OFFSET_BITS);
    localparam int CFG_IDX_BITS     = 2;
    localparam int CFG_DATA_BITS    = 40;
    localparam logic [OFFSET_BITS-1:0] THRESH_RESET = OFFSET_BITS'(40000000);

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DISTRIBUTED = 2'd0,
        CFG_THRESHOLD   = 2'd1,
        CFG_WORLD_SIZE  = 2'd2,
        CFG_WIDE_PAD    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] param_elements;
        logic                   final_param;
    } in_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0]    param_start;
        logic [OFFSET_BITS-1:0]    param_end;
        logic [BUCKET_ID_BITS-1:0] bucket_index;
        logic                      bucket_closed;
        logic [OFFSET_BITS-1:0]    bucket_begin;
        logic [OFFSET_BITS-1:0]    bucket_finish;
        logic [OFFSET_BITS-1:0]    bucket_unpadded;
        logic [OFFSET_BITS-1:0]    total_padded;
        logic [OFFSET_BITS-1:0]    total_unpadded;
        logic                      overflow;
    } out_t;

    typedef struct packed {
        logic load;
        logic calc_start;
        logic calc_end;
        logic calc_span;
        logic calc_test;
        logic div_step;
        logic calc_gap;
        logic calc_pad;
        logic write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } dp_status_t;

endpackage
`default_nettype wire

@@ rtl/core/gbl_ctrl.sv @@
`default_nettype none
module gbl_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  gbl_pkg::dp_status_t     status,
    output gbl_pkg::ctrl_cmd_t      cmd
);
    import gbl_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_START = 9'b000000010,
        ST_END   = 9'b000000100,
        ST_SPAN  = 9'b000001000,
        ST_TEST  = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_GAP   = 9'b001000000,
        ST_PAD   = 9'b010000000,
        ST_WRITE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.calc_start = 1'b1;
                state_next     = ST_END;
            end
            ST_END: begin
                cmd.calc_end = 1'b1;
                state_next   = ST_SPAN;
            end
            ST_SPAN: begin
                cmd.calc_span = 1'b1;
                state_next    = ST_TEST;
            end
            ST_TEST: begin
                cmd.calc_test = 1'b1;
                state_next    = status.need_div ? ST_DIV : ST_PAD;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP: begin
                cmd.calc_gap = 1'b1;
                state_next   = ST_PAD;
            end
            ST_PAD: begin
                cmd.calc_pad = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.write) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/gbl_datapath.sv @@
`default_nettype none
module gbl_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [gbl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [gbl_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  gbl_pkg::in_t                           s_data,
    input  gbl_pkg::ctrl_cmd_t                     cmd,
    output gbl_pkg::dp_status_t                    status,
    output gbl_pkg::out_t                          m_data
);
    import gbl_pkg::*;

    localparam logic [START_ALIGN_BITS:0] START_ALIGN = (START_ALIGN_BITS+1)'(1 << START_ALIGN_BITS);

    function automatic logic [OFFSET_BITS:0] sat_add(input offset_t a, input offset_t b);
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[OFFSET_BITS]) begin
            s = {1'b1, {OFFSET_BITS{1'b1}}};
        end
        return s;
    endfunction

    // configuration
    logic                  dist_reg;
    offset_t               thresh_reg;
    logic [WS_BITS-1:0]    ws_reg;
    logic                  wide_reg;

    // per-item working registers
    offset_t               elems_reg;
    logic                  last_reg;
    logic [LCM_BITS-1:0]   lcm_reg;
    offset_t               start_reg;
    offset_t               end_reg;
    offset_t               span_reg;
    logic                  closed_reg;
    logic                  iovf_reg;
    logic [LCM_BITS-1:0]   rem_reg;
    offset_t               dvd_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [LCM_BITS-1:0]   gap_reg;
    offset_t               bend_reg;

    // layout state
    offset_t               next_off_reg, next_off_next;
    offset_t               obs_reg, obs_next;
    logic [BUCKET_ID_BITS-1:0] bucket_reg, bucket_next;
    offset_t               usum_reg, usum_next;
    logic                  sticky_reg, sticky_next;

    out_t                  out_reg;

    logic [TZ_BITS-1:0]    tz;
    logic [TZ_BITS-1:0]    cap;
    logic [TZ_BITS-1:0]    sh;
    logic [LCM_BITS-1:0]   lcm_calc;
    logic [OFFSET_BITS:0]  start_sum;
    logic [OFFSET_BITS:0]  end_sum;
    logic [OFFSET_BITS:0]  span_diff;
    logic [OFFSET_BITS:0]  pad_sum;
    logic [OFFSET_BITS:0]  usum_sum;
    logic [LCM_BITS:0]     div_shift;
    logic                  closed_calc;

    // lcm(ws, 2^k) = ws << (k - min(tz(ws), k))
    always_comb begin
        tz = '0;
        for (int i = WS_BITS - 1; i >= 0; i--) begin
            if (ws_reg[i]) begin
                tz = TZ_BITS'(i);
            end
        end
        cap      = wide_reg ? TZ_BITS'(WIDE_ALIGN_LOG2) : TZ_BITS'(END_ALIGN_LOG2);
        sh       = (tz >= cap) ? '0 : cap - tz;
        lcm_calc = LCM_BITS'(ws_reg) << sh;
    end

    assign start_sum = sat_add(next_off_reg,
        OFFSET_BITS'(START_ALIGN - {1'b0, next_off_reg[START_ALIGN_BITS-1:0]}));
    assign end_sum   = sat_add(start_reg, elems_reg);
    assign span_diff = {1'b0, end_reg} - {1'b0, obs_reg};
    assign pad_sum   = sat_add(end_reg, OFFSET_BITS'(gap_reg));
    assign usum_sum  = sat_add(usum_reg, span_reg);
    assign div_shift = {rem_reg, dvd_reg[OFFSET_BITS-1]};
    assign closed_calc = last_reg || (span_reg >= thresh_reg);

    assign status.need_div = closed_calc && dist_reg && (lcm_reg != '0);
    assign status.div_last = (cnt_reg == DIV_CNT_BITS'(OFFSET_BITS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg   <= 1'b0;
            thresh_reg <= THRESH_RESET;
            ws_reg     <= WS_BITS'(1);
            wide_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DISTRIBUTED: dist_reg   <= cfg_wdata[0];
                CFG_THRESHOLD:   thresh_reg <= cfg_wdata[OFFSET_BITS-1:0];
                CFG_WORLD_SIZE:  ws_reg     <= cfg_wdata[WS_BITS-1:0];
                CFG_WIDE_PAD:    wide_reg   <= cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            elems_reg <= s_data.param_elements;
            last_reg  <= s_data.final_param;
            lcm_reg   <= lcm_calc;
            iovf_reg  <= 1'b0;
        end
        if (cmd.calc_start) begin
            if (dist_reg && (next_off_reg[START_ALIGN_BITS-1:0] != '0)) begin
                start_reg <= start_sum[OFFSET_BITS-1:0];
                iovf_reg  <= iovf_reg | start_sum[OFFSET_BITS];
            end else begin
                start_reg <= next_off_reg;
            end
        end
        if (cmd.calc_end) begin
            end_reg  <= end_sum[OFFSET_BITS-1:0];
            iovf_reg <= iovf_reg | end_sum[OFFSET_BITS];
        end
        if (cmd.calc_span) begin
            span_reg <= span_diff[OFFSET_BITS] ? '0 : span_diff[OFFSET_BITS-1:0];
        end
        if (cmd.calc_test) begin
            closed_reg <= closed_calc;
            gap_reg    <= '0;
            rem_reg    <= '0;
            dvd_reg    <= end_reg;
            cnt_reg    <= '0;
        end
        // restoring remainder, one dividend bit per step
        if (cmd.div_step) begin
            if (div_shift >= {1'b0, lcm_reg}) begin
                rem_reg <= LCM_BITS'(div_shift - {1'b0, lcm_reg});
            end else begin
                rem_reg <= div_shift[LCM_BITS-1:0];
            end
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.calc_gap) begin
            gap_reg <= (rem_reg == '0) ? '0 : lcm_reg - rem_reg;
        end
        if (cmd.calc_pad) begin
            bend_reg <= pad_sum[OFFSET_BITS-1:0];
            iovf_reg <= iovf_reg | pad_sum[OFFSET_BITS];
        end
    end

    always_comb begin
        next_off_next = next_off_reg;
        obs_next      = obs_reg;
        bucket_next   = bucket_reg;
        usum_next     = usum_reg;
        sticky_next   = sticky_reg;
        if (cmd.write) begin
            sticky_next = sticky_reg | iovf_reg;
            if (closed_reg) begin
                next_off_next = bend_reg;
                obs_next      = bend_reg;
                bucket_next   = bucket_reg + 1'b1;
                usum_next     = usum_sum[OFFSET_BITS-1:0];
                sticky_next   = sticky_reg | iovf_reg | usum_sum[OFFSET_BITS];
            end else begin
                next_off_next = end_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_off_reg <= '0;
            obs_reg      <= '0;
            bucket_reg   <= '0;
            usum_reg     <= '0;
            sticky_reg   <= 1'b0;
        end else begin
            next_off_reg <= next_off_next;
            obs_reg      <= obs_next;
            bucket_reg   <= bucket_next;
            usum_reg     <= usum_next;
            sticky_reg   <= sticky_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            out_reg.param_start     <= start_reg;
            out_reg.param_end       <= end_reg;
            out_reg.bucket_index    <= bucket_reg;
            out_reg.bucket_closed   <= closed_reg;
            out_reg.bucket_begin    <= closed_reg ? obs_reg : '0;
            out_reg.bucket_finish   <= closed_reg ? bend_reg : '0;
            out_reg.bucket_unpadded <= closed_reg ? span_reg : '0;
            out_reg.total_padded    <= last_reg ? next_off_next : '0;
            out_reg.total_unpadded  <= last_reg ? usum_next : '0;
            out_reg.overflow        <= sticky_next;
        end
    end

    assign m_data = out_reg;

endmodule
`default_nettype wire

@@ rtl/core/gradient_bucket_layout.sv @@
`default_nettype none
// Each input beat steps through start pad, end, span and close test, then pad
// and write; a closed bucket padded to the lcm alignment also runs the 40-step
// remainder loop that sizes the bucket-end pad. One item is in work at a time.
// Reset (aresetn low, synchronous): layout restarts at offset zero, bucket zero,
// overflow clear, and configuration registers return to their defaults.
module gradient_bucket_layout (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [gbl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [gbl_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    // parameter beats in
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  gbl_pkg::in_t                           s_data,
    // layout result beats out
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output gbl_pkg::out_t                          m_data
);
    import gbl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: accept a beat, step start pad, end, span, close test, the
    // optional remainder loop, pad and write-back. The result sits in an
    // output register, so the next beat is taken while it waits.
    gbl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: config registers, offset arithmetic with saturation,
    // the shared remainder unit and the layout state.
    gbl_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

@@ rtl/core/gbl_checker.sv @@
`default_nettype none
module gbl_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  gbl_pkg::out_t                          m_data
);
    import gbl_pkg::*;

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // one item in work: no beat taken right after another
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    a_open_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.bucket_closed |-> m_data.bucket_begin == '0 &&
            m_data.bucket_finish == '0 && m_data.bucket_unpadded == '0)
        else $error("bucket fields set on an open bucket");

    a_final_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.total_padded != '0 |-> m_data.bucket_closed)
        else $error("totals reported without closing a bucket");

    a_end_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.param_end >= m_data.param_start)
        else $error("parameter end before its start");

endmodule

bind gradient_bucket_layout gbl_checker u_gbl_checker (.*);
`default_nettype wire

@@ dv/tb_gradient_bucket_layout.sv @@
`timescale 1ns / 100ps
module tb_gradient_bucket_layout;
    import gbl_pkg::*;

    // Quiet cycles allowed before the run is declared hung: room for the longest
    // item with its remainder loop, plus random receiver stalls and sender gaps.
    localparam int STALL_LIMIT = 2000;
    localparam logic [63:0] OFFSET_MAX   = (64'(1) << OFFSET_BITS) - 1;
    localparam logic [63:0] PARAM_ALIGN  = 64'(1) << START_ALIGN_BITS;
    localparam logic [63:0] BUCKET_ALIGN = 64'(1) << END_ALIGN_LOG2;
    localparam logic [63:0] WIDE_ALIGN   = 64'(1) << WIDE_ALIGN_LOG2;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Register shadows, starting at the reset defaults.
    logic dist_mode = 1'b0;
    logic [63:0] threshold = 64'd40000000;
    logic [63:0] ranks = 64'd1;
    logic wide_pad = 1'b0;

    // Layout state of the predictor.
    logic [63:0] next_off = '0;
    logic [63:0] bucket_base = '0;
    logic [BUCKET_ID_BITS-1:0] bucket_num = '0;
    logic [63:0] unpadded_total = '0;
    logic ovf_seen = 1'b0;
    logic step_ovf;

    out_t pending_layouts[$];
    int mismatch_count = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;

    gradient_bucket_layout i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Layout predictor
    // ------------------------------------------------------------------

    // Add and clamp at the top of the offset range; flag the clamp.
    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        if (a > OFFSET_MAX) begin
            step_ovf = 1'b1;
            a = OFFSET_MAX;
        end
        if (b > OFFSET_MAX - a) begin
            step_ovf = 1'b1;
            return OFFSET_MAX;
        end
        return a + b;
    endfunction

    // Round up to a multiple of align; an align of zero leaves v alone.
    function automatic logic [63:0] round_up(logic [63:0] v, logic [63:0] align);
        logic [63:0] rem;
        if (align == 0) return v;
        rem = v % align;
        if (rem == 0) return v;
        return sat_sum(v, align - rem);
    endfunction

    function automatic logic [63:0] lcm_of(logic [63:0] a, logic [63:0] b);
        logic [63:0] x, y, t;
        if (a == 0 || b == 0) return '0;
        x = a;
        y = b;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return (a / x) * b;
    endfunction

    // Place one parameter in the flat buffer and advance the layout state.
    function automatic out_t place_param(in_t p);
        out_t r;
        logic [63:0] p_start, p_end, span, align, bend;
        logic shut;
        r = '0;
        step_ovf = 1'b0;
        p_start = next_off;
        if (dist_mode) p_start = round_up(p_start, PARAM_ALIGN);
        p_end = sat_sum(p_start, 64'(p.param_elements));
        span = (p_end >= bucket_base) ? p_end - bucket_base : '0;
        shut = p.final_param || span >= threshold;
        r.param_start   = p_start[OFFSET_BITS-1:0];
        r.param_end     = p_end[OFFSET_BITS-1:0];
        r.bucket_index  = bucket_num;
        r.bucket_closed = shut;
        if (shut) begin
            bend = p_end;
            if (dist_mode) begin
                align = lcm_of(ranks, BUCKET_ALIGN);
                if (wide_pad) align = lcm_of(align, WIDE_ALIGN);
                bend = round_up(p_end, align);
            end
            r.bucket_begin    = bucket_base[OFFSET_BITS-1:0];
            r.bucket_finish   = bend[OFFSET_BITS-1:0];
            r.bucket_unpadded = span[OFFSET_BITS-1:0];
            unpadded_total = sat_sum(unpadded_total, span);
            next_off = bend;
            bucket_base = bend;
            bucket_num = bucket_num + 1'b1;
        end else begin
            next_off = p_end;
        end
        if (step_ovf) ovf_seen = 1'b1;
        // Totals only show on the last parameter of a layout.
        if (p.final_param) begin
            r.total_padded   = next_off[OFFSET_BITS-1:0];
            r.total_unpadded = unpadded_total[OFFSET_BITS-1:0];
        end
        r.overflow = ovf_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_miss(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("mismatch on result %0d, %s: got %0h want %0h",
                 results_seen, what, got, want);
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want) report_miss(what, got, want);
    endtask

    task automatic check_beat(out_t got);
        out_t want;
        if (pending_layouts.size() == 0) begin
            report_miss("beat with nothing expected", 64'(got), '0);
            return;
        end
        want = pending_layouts.pop_front();
        check_field("param_start", 64'(got.param_start), 64'(want.param_start));
        check_field("param_end", 64'(got.param_end), 64'(want.param_end));
        check_field("bucket_index", 64'(got.bucket_index), 64'(want.bucket_index));
        check_field("bucket_closed", 64'(got.bucket_closed), 64'(want.bucket_closed));
        check_field("bucket_begin", 64'(got.bucket_begin), 64'(want.bucket_begin));
        check_field("bucket_finish", 64'(got.bucket_finish), 64'(want.bucket_finish));
        check_field("bucket_unpadded", 64'(got.bucket_unpadded),
                    64'(want.bucket_unpadded));
        check_field("total_padded", 64'(got.total_padded), 64'(want.total_padded));
        check_field("total_unpadded", 64'(got.total_unpadded),
                    64'(want.total_unpadded));
        check_field("overflow", 64'(got.overflow), 64'(want.overflow));
    endtask

    // Sample result beats at the rising edge, against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_beat(m_data);
            results_seen++;
        end
    end

    // Receiver back-pressure; drive at the falling edge only.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Hang detector: count cycles in which no beat and no register write moves.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one parameter beat. Valid stays up after acceptance until the next
    // falling edge, where it either carries the next beat or drops.
    task automatic push_param(offset_t elems, logic fin);
        in_t beat;
        beat.param_elements = elems;
        beat.final_param = fin;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
        pending_layouts.insert(pending_layouts.size(), place_param(beat));
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_layouts.size() != 0) @(posedge aclk);
    endtask

    // Write one register; call only with the block idle.
    task automatic write_reg(cfg_idx_t idx, offset_t value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DISTRIBUTED: dist_mode = value[0];
            CFG_THRESHOLD:   threshold = 64'(value);
            CFG_WORLD_SIZE:  ranks = 64'(value[WS_BITS-1:0]);
            CFG_WIDE_PAD:    wide_pad = value[0];
            default: ;
        endcase
    endtask

    // Random register setting; keep rank counts modest so the buffer stays
    // far below the offset range until the saturation test.
    task automatic pick_setting();
        offset_t th;
        offset_t rk;
        case ($urandom_range(9))
            0:          th = '0;
            1:          th = offset_t'(1);
            2, 3, 4, 5: th = offset_t'($urandom_range(1, 4000));
            6, 7, 8:    th = offset_t'($urandom_range(4000, 1 << 20));
            default:    th = offset_t'({$urandom, $urandom});
        endcase
        case ($urandom_range(7))
            0:       rk = '0;
            1:       rk = offset_t'(1);
            default: rk = offset_t'($urandom_range(2, 1024));
        endcase
        // Junk in the upper data bits of the one-bit registers must be ignored.
        write_reg(CFG_DISTRIBUTED, offset_t'({$urandom, $urandom}));
        write_reg(CFG_THRESHOLD, th);
        write_reg(CFG_WORLD_SIZE, rk);
        write_reg(CFG_WIDE_PAD, offset_t'({$urandom, $urandom}));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: no padding, 40M-element buckets, beats after the final.
    task automatic test_reset_defaults();
        push_param(offset_t'(0), 1'b0);
        push_param(offset_t'(100), 1'b0);
        push_param(offset_t'(40000000), 1'b0);
        push_param(offset_t'(5), 1'b1);
        push_param(offset_t'(7), 1'b0);
        push_param(offset_t'(3), 1'b1);
    endtask

    // Parameter starts padded to 64, bucket end padded to lcm(3, 128).
    task automatic test_start_padding();
        drain();
        write_reg(CFG_DISTRIBUTED, offset_t'(1));
        write_reg(CFG_WORLD_SIZE, offset_t'(3));
        write_reg(CFG_THRESHOLD, offset_t'(1000));
        push_param(offset_t'(1), 1'b0);
        push_param(offset_t'(63), 1'b0);
        push_param(offset_t'(64), 1'b0);
        push_param(offset_t'(65), 1'b0);
        push_param(offset_t'(1000), 1'b0);
        push_param(offset_t'(0), 1'b1);
    endtask

    // Wide padding with the largest rank counts, then a zero rank count,
    // which leaves bucket ends unpadded.
    task automatic test_end_alignment();
        drain();
        write_reg(CFG_WIDE_PAD, offset_t'(1));
        write_reg(CFG_WORLD_SIZE, offset_t'(65536));
        write_reg(CFG_THRESHOLD, offset_t'(1));
        push_param(offset_t'(1), 1'b0);
        push_param(offset_t'(65536), 1'b1);
        drain();
        write_reg(CFG_WORLD_SIZE, offset_t'((1 << WS_BITS) - 1));
        push_param(offset_t'(5), 1'b1);
        drain();
        write_reg(CFG_WORLD_SIZE, offset_t'(0));
        push_param(offset_t'(10), 1'b0);
        push_param(offset_t'(0), 1'b1);
    endtask

    // Zero threshold closes every bucket, all-ones never closes before the
    // final beat, and a span exactly at the threshold closes.
    task automatic test_threshold_edges();
        drain();
        write_reg(CFG_DISTRIBUTED, offset_t'(0));
        write_reg(CFG_WIDE_PAD, offset_t'(0));
        write_reg(CFG_THRESHOLD, offset_t'(0));
        push_param(offset_t'(0), 1'b0);
        push_param(offset_t'(9), 1'b0);
        drain();
        write_reg(CFG_THRESHOLD, '1);
        push_param(offset_t'(1000), 1'b0);
        push_param(offset_t'(2), 1'b0);
        push_param(offset_t'(0), 1'b1);
        drain();
        write_reg(CFG_THRESHOLD, offset_t'(50));
        push_param(offset_t'(50), 1'b0);
        push_param(offset_t'(49), 1'b0);
        push_param(offset_t'(1), 1'b0);
    endtask

    // Mostly well-formed layouts (a run of parameters ending in a final one)
    // with random sizes, some broken runs, new settings every ~100 beats.
    task automatic test_random_layout(int idle_pct, int stall_pct, int count);
        int sent, since_setting, run_len;
        offset_t elems;
        logic fin;
        drain();
        send_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        pick_setting();
        sent = 0;
        since_setting = 0;
        while (sent < count) begin
            run_len = $urandom_range(1, 12);
            for (int k = 0; k < run_len; k++) begin
                case ($urandom_range(19))
                    0:                   elems = '0;
                    1, 2, 3, 4, 5, 6, 7,
                    8, 9, 10:            elems = offset_t'($urandom_range(1, 300));
                    11, 12, 13, 14,
                    15, 16:              elems = offset_t'($urandom_range(1, 65536));
                    default:             elems = offset_t'($urandom_range(1, 1 << 24));
                endcase
                fin = (k == run_len - 1);
                // Break the run now and then: early final or missing final.
                if ($urandom_range(19) == 0) fin = ~fin;
                push_param(elems, fin);
                sent++;
                since_setting++;
                // Sometimes hold off until the block has fully emptied.
                if ($urandom_range(39) == 0) drain();
            end
            if (since_setting >= 100) begin
                drain();
                pick_setting();
                since_setting = 0;
            end
        end
    endtask

    // Saturate every offset; the overflow flag sticks, so this runs last.
    task automatic test_overflow_saturation();
        drain();
        send_idle_pct = 20;
        sink_stall_pct = 20;
        write_reg(CFG_DISTRIBUTED, offset_t'(1));
        write_reg(CFG_WORLD_SIZE, offset_t'(3));
        write_reg(CFG_WIDE_PAD, offset_t'(1));
        write_reg(CFG_THRESHOLD, offset_t'(1000));
        push_param(offset_t'({$urandom, $urandom}), 1'b0);
        push_param('1, 1'b0);
        for (int k = 0; k < 6; k++)
            push_param(offset_t'({$urandom, $urandom}), 1'(k == 3));
        push_param(offset_t'(0), 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_start_padding();
        test_end_alignment();
        test_threshold_edges();
        test_random_layout(0, 0, 200);
        test_random_layout(64, 0, 200);
        test_random_layout(0, 64, 200);
        test_random_layout(37, 37, 200);
        test_overflow_saturation();

        // Let the last result land, then allow one more full item time.
        drain();
        repeat (64) @(posedge aclk);
        if (mismatch_count == 0 && pending_layouts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
